>>> hw/rtl/trial_division_prime_check_assert.svh
// Assertion macros for the prime check RTL.
`ifndef TRIAL_DIVISION_PRIME_CHECK_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_CHECK_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TDPC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tdpc assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define TDPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tdpc assertion failed: next-cycle implication");

`endif

>>> hw/rtl/tdpc_pkg.sv
package tdpc_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EVAL
  } tdpc_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic init_div;
    logic div_step;
    logic next_div;
  } tdpc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic lt_two;
    logic sq_gt_n;
    logic div_last;
    logic rem_zero;
  } tdpc_status_t;

  localparam int unsigned FirstDivisor = 2;

endpackage

>>> hw/rtl/tdpc_dp.sv
module tdpc_dp import tdpc_pkg::*; #(
  parameter int unsigned NUM_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [NUM_BITS-1:0] candidate_i,
  input  tdpc_cmd_t           cmd_i,
  output tdpc_status_t        status_o
);

  // The divisor never passes the square root of the largest candidate by more than one.
  localparam int unsigned DW = (NUM_BITS + 1) / 2 + 1;
  localparam int unsigned RW = DW + 1;
  localparam int unsigned SW = 2 * DW;
  localparam int unsigned CW = $clog2(NUM_BITS);

  logic [NUM_BITS-1:0] n_q, n_d;
  logic [NUM_BITS-1:0] sh_q, sh_d;
  logic [DW-1:0]       d_q, d_d;
  logic [SW-1:0]       sq_q, sq_d;
  logic [DW-1:0]       rem_q, rem_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [RW-1:0]       r_shift;

  assign r_shift = {rem_q, sh_q[NUM_BITS-1]};

  always_comb begin
    n_d   = n_q;
    sh_d  = sh_q;
    d_d   = d_q;
    sq_d  = sq_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      n_d  = candidate_i;
      d_d  = DW'(FirstDivisor);
      sq_d = SW'(FirstDivisor * FirstDivisor);
    end
    if (cmd_i.init_div) begin
      sh_d  = n_q;
      rem_d = '0;
      cnt_d = CW'(NUM_BITS - 1);
    end
    // One restoring remainder step per cycle, candidate bits MSB first.
    if (cmd_i.div_step) begin
      if (r_shift >= RW'(d_q)) begin
        rem_d = DW'(r_shift - RW'(d_q));
      end else begin
        rem_d = DW'(r_shift);
      end
      sh_d  = {sh_q[NUM_BITS-2:0], 1'b0};
      cnt_d = cnt_q - CW'(1);
    end
    // The square of the next divisor is (d+1)^2 = d^2 + 2d + 1.
    if (cmd_i.next_div) begin
      d_d  = d_q + DW'(1);
      sq_d = sq_q + SW'({d_q, 1'b1});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    sh_q  <= sh_d;
    d_q   <= d_d;
    sq_q  <= sq_d;
    rem_q <= rem_d;
  end

  assign status_o.lt_two   = (n_q < NUM_BITS'(FirstDivisor));
  assign status_o.sq_gt_n  = (sq_q > SW'(n_q));
  assign status_o.div_last = (cnt_q == '0);
  assign status_o.rem_zero = (rem_q == '0);

endmodule

>>> hw/rtl/tdpc_ctrl.sv
module tdpc_ctrl import tdpc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  tdpc_status_t status_i,
  output tdpc_cmd_t    cmd_o,
  output logic         busy_o,
  output logic         done_o,
  output logic         is_prime_o
);

  tdpc_state_e state_q, state_d;
  logic        done_q, done_d;
  logic        prime_q, prime_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      prime_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      prime_q <= prime_d;
    end
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    prime_d = prime_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.lt_two) begin
          done_d  = 1'b1;
          prime_d = 1'b0;
          state_d = ST_IDLE;
        end else if (status_i.sq_gt_n) begin
          done_d  = 1'b1;
          prime_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.init_div = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status_i.rem_zero) begin
          done_d  = 1'b1;
          prime_d = 1'b0;
          state_d = ST_IDLE;
        end else begin
          cmd_o.next_div = 1'b1;
          state_d        = ST_CHECK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign done_o     = done_q;
  assign is_prime_o = prime_q;

endmodule

>>> hw/rtl/trial_division_prime_check.sv
// After start loads the candidate, the check state decides those below 2 or up to 3; otherwise
// each divisor tried runs the bit-serial remainder unit and is evaluated, ending on a zero remainder
// or when the divisor's square passes the candidate; the receiver cannot stall done_o.
// Throughput: one transaction at a time; a new start is taken in the cycle done is high.
// Worst case for 16 bits is 254 divisors tried.
// Reset is asynchronous and active low; it returns the controller to idle with done low.
`include "trial_division_prime_check_assert.svh"

module trial_division_prime_check import tdpc_pkg::*; #(
  parameter int unsigned NUM_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [NUM_BITS-1:0] candidate_i,
  output logic                done_o,
  output logic                is_prime_o
);

  tdpc_cmd_t    cmd;
  tdpc_status_t status;

  tdpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy),
    .done_o     (done_o),
    .is_prime_o (is_prime_o)
  );

  tdpc_dp #(
    .NUM_BITS (NUM_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .candidate_i (candidate_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // A result only follows work in progress, and the block is free again when it shows.
  `TDPC_ASSERT_SAME(a_done_after_busy, done_o, $past(busy))
  `TDPC_ASSERT_SAME(a_done_not_busy, done_o, !busy)
  `TDPC_ASSERT_NEXT(a_start_takes, start && !busy, busy)
  `TDPC_ASSERT_SAME(a_one_command, 1'b1, $onehot0(cmd))

endmodule

>>> tb/prime_verdict_checker.sv
module prime_verdict_checker import tdpc_pkg::*; #(
  parameter int unsigned NUM_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                busy,
  input  logic [NUM_BITS-1:0] candidate_i,
  input  logic                done_o,
  input  logic                is_prime_o,
  output int                  fail_count,
  output int                  verdicts_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Expected verdicts paired with their candidates, oldest first.
  bit                expected_verdicts[$];
  logic [NUM_BITS-1:0] candidates_in_flight[$];

  function automatic bit prime_by_division(logic [NUM_BITS-1:0] cand);
    longint unsigned value;
    longint unsigned divisor;
    value = cand;
    if (value < 2) return 1'b0;
    for (divisor = FirstDivisor; divisor * divisor <= value; divisor++) begin
      if (value % divisor == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  initial fail_count = 0;
  assign verdicts_pending = expected_verdicts.size();

  always @(posedge clk_i) begin
    bit                  want;
    logic [NUM_BITS-1:0] cand;
    if (rst_ni) begin
      // Retire the finished transaction before queuing a new one, since a start
      // can be taken in the same cycle as done.
      if (done_o) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: result with no transaction outstanding, is_prime=%0b",
                   $time, is_prime_o);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_verdicts.pop_front();
          cand = candidates_in_flight.pop_front();
          if (is_prime_o !== want) begin
            $display("%0t: candidate %0d: is_prime expected %0b, actual %0b",
                     $time, cand, want, is_prime_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        expected_verdicts.push_back(prime_by_division(candidate_i));
        candidates_in_flight.push_back(candidate_i);
      end
    end
  end

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CandBits     = 16;
  localparam int          RandomItems  = 120;
  localparam int          StallLimit   = 30000;
  localparam int          SettleCycles = 20;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [CandBits-1:0] candidate_i;
  logic                done_o;
  logic                is_prime_o;
  int                  fail_count;
  int                  verdicts_pending;
  int                  idle_cycles = 0;
  bit                  burst_mode = 1'b0;

  always #4 clk_i = ~clk_i;

  trial_division_prime_check #(.NUM_BITS(CandBits)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .candidate_i(candidate_i),
    .done_o     (done_o),
    .is_prime_o (is_prime_o)
  );

  prime_verdict_checker #(.NUM_BITS(CandBits)) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .candidate_i     (candidate_i),
    .done_o          (done_o),
    .is_prime_o      (is_prime_o),
    .fail_count      (fail_count),
    .verdicts_pending(verdicts_pending)
  );

  // Ends the run if the block stops taking or returning transactions.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, StallLimit);
        $display("FAIL trial_division_prime_check");
        $finish;
      end
    end
  end

  // Start stays high across back-to-back transactions, so it is only lowered
  // when a gap follows.
  task automatic issue_candidate(logic [CandBits-1:0] value);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    candidate_i <= value;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Uniform and small numbers, and many near the boundaries of the divisor search:
  // squares and their neighbours, products of two factors and the top of the range.
  function automatic logic [CandBits-1:0] draw_candidate();
    int unsigned a;
    int unsigned b;
    a = $urandom_range(2, 255);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return CandBits'($urandom_range(0, 65535));
      4, 5:       return CandBits'($urandom_range(0, 300));
      6:          return CandBits'(a * a);
      7:          return CandBits'(a * a + $urandom_range(0, 2) - 1);
      8: begin
        b = $urandom_range(a, 65535 / a);
        return CandBits'(a * b);
      end
      default:    return CandBits'($urandom_range(65000, 65535));
    endcase
  endfunction

  initial begin
    logic [CandBits-1:0] directed[$];
    rst_ni      = 1'b0;
    start       = 1'b0;
    candidate_i = '0;
    directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd25, 16'd49,
                 16'd97, 16'd257, 16'd32749, 16'd32768, 16'd63001, 16'd65025,
                 16'd65519, 16'd65521, 16'd65535, 16'hAAAA, 16'h5555};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) issue_candidate(directed[i]);
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 20 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      issue_candidate(draw_candidate());
    end
    start <= 1'b0;
    // Let the checker queue the last transaction before waiting on the queue.
    @(posedge clk_i);

    wait (verdicts_pending == 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && verdicts_pending == 0) begin
      $display("PASS trial_division_prime_check");
    end else begin
      $display("FAIL trial_division_prime_check");
    end
    $finish;
  end

endmodule
